FILE: rtl/pvc_pkg.sv
// pvc_pkg: constants, types and helpers shared by the pose velocity controller
package pvc_pkg;

	localparam int PI_Q12     = 12868;
	localparam int TWO_PI_Q12 = 25736;
	localparam int PI_Q24     = 52707179;
	localparam int ATAN_LEN   = 20;

	// cordic datapath width, covers gain growth of the scaled offsets
	localparam int CW = 28;

	typedef logic signed [CW-1:0] cor_word_t;

	// atan(2^-i) in units of 2^-24 rad
	localparam cor_word_t ATAN_Q24 [ATAN_LEN] = '{
		28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
		28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
		28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024,
		28'sd512, 28'sd256, 28'sd128, 28'sd64, 28'sd32
	};

	// configuration register indexes
	localparam logic [2:0] REG_TEAM_AWAY     = 3'd0;
	localparam logic [2:0] REG_GOAL_X        = 3'd1;
	localparam logic [2:0] REG_GOAL_Y        = 3'd2;
	localparam logic [2:0] REG_LINE_X        = 3'd3;
	localparam logic [2:0] REG_GAIN_XY       = 3'd4;
	localparam logic [2:0] REG_GAIN_TURN     = 3'd5;
	localparam logic [2:0] REG_MAX_SPEED_XY  = 3'd6;
	localparam logic [2:0] REG_MAX_TURN_RATE = 3'd7;

	// payload of one cordic stage, velocities ride along
	typedef struct packed {
		cor_word_t          x;
		cor_word_t          y;
		cor_word_t          z;
		logic               zero;
		logic signed [16:0] th;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
	} cor_t;

	function automatic logic signed [15:0] clamp_sym(input logic signed [23:0] v,
			input logic [14:0] lim);
		logic signed [23:0] l;
		logic signed [23:0] r;
		l = 24'($signed({1'b0, lim}));
		priority if (v > l) begin
			r = l;
		end else if (v < -l) begin
			r = -l;
		end else begin
			r = v;
		end
		return 16'(r);
	endfunction

endpackage

FILE: rtl/pose_velocity_controller_top.sv
// pose_velocity_controller_top: pipelined proportional position and heading controller
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata pose and target, s_tuser mode
//  m_       out  m_tvalid/m_tready  m_tdata velocity command
//  cfg_     in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// one beat per cycle sustained while m_tready stays high; the pipeline length is set by the
// unrolled cordic with one iteration per stage
// arst_n clears valid bits and loads the register defaults
// each stage holds its beat only while the next one is full and stalled, so
// bubbles close up and a waiting result blocks entry only once every stage is full
module pose_velocity_controller_top
	import pvc_pkg::*;
#(
	parameter int CORDIC_STEPS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// robot_x[15:0], robot_y[31:16], robot_heading[46:32], target_x[62:47],
	// target_y[78:63], zero pad[79]
	input  logic [79:0] s_tdata,
	// command[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// vel_x[15:0], vel_y[31:16], turn_rate[47:32]
	output logic [47:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration registers
	logic               team_away_q;
	logic signed [15:0] goal_x_q, goal_y_q, line_x_q;
	logic [7:0]         gain_xy_q, gain_turn_q;
	logic [14:0]        max_speed_xy_q, max_turn_rate_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			team_away_q     <= 1'b0;
			goal_x_q        <= 16'sd6242;
			goal_y_q        <= 16'sd0;
			line_x_q        <= -16'sd4162;
			gain_xy_q       <= 8'd80;
			gain_turn_q     <= 8'd32;
			max_speed_xy_q  <= 15'd2048;
			max_turn_rate_q <= 15'd25736;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TEAM_AWAY:     team_away_q     <= cfg_data[0];
				REG_GOAL_X:        goal_x_q        <= $signed(cfg_data);
				REG_GOAL_Y:        goal_y_q        <= $signed(cfg_data);
				REG_LINE_X:        line_x_q        <= $signed(cfg_data);
				REG_GAIN_XY:       gain_xy_q       <= cfg_data[7:0];
				REG_GAIN_TURN:     gain_turn_q     <= cfg_data[7:0];
				REG_MAX_SPEED_XY:  max_speed_xy_q  <= cfg_data[14:0];
				REG_MAX_TURN_RATE: max_turn_rate_q <= cfg_data[14:0];
				default:           team_away_q     <= team_away_q;
			endcase
		end
	end

	// stage handshake
	logic v_s1, v_s2, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s4, rdy_s5, rdy_s6;
	logic cv_s3 [CORDIC_STEPS];
	logic c_rdy [CORDIC_STEPS];

	assign rdy_s6   = !v_s6 || m_tready;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s2   = !v_s2 || c_rdy[0];
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// stage 1: mirror, heading wrap, offsets
	logic signed [15:0] rx_in, ry_in, tx_in, ty_in;
	logic signed [14:0] th_in;
	logic signed [16:0] rx_m, ry_m, tx_m, ty_m, th_sum, th_wrap, th_c;
	logic signed [17:0] dvx_c, dvy_c, gdx_c, gdy_c;

	assign rx_in = $signed(s_tdata[15:0]);
	assign ry_in = $signed(s_tdata[31:16]);
	assign th_in = $signed(s_tdata[46:32]);
	assign tx_in = $signed(s_tdata[62:47]);
	assign ty_in = $signed(s_tdata[78:63]);

	always_comb begin
		rx_m = team_away_q ? -17'(rx_in) : 17'(rx_in);
		ry_m = team_away_q ? -17'(ry_in) : 17'(ry_in);
		tx_m = team_away_q ? -17'(tx_in) : 17'(tx_in);
		ty_m = team_away_q ? -17'(ty_in) : 17'(ty_in);
		// one period up lands in [0, 2 periods), so one conditional subtract wraps it
		th_sum  = 17'(th_in) + 17'(TWO_PI_Q12);
		th_wrap = (th_sum >= 17'(TWO_PI_Q12)) ? th_sum - 17'(TWO_PI_Q12) : th_sum;
		th_c    = team_away_q ? th_wrap - 17'(PI_Q12) : 17'(th_in);
		dvx_c   = (s_tuser ? 18'(line_x_q) : 18'(tx_m)) - 18'(rx_m);
		dvy_c   = 18'(ty_m) - 18'(ry_m);
		gdx_c   = 18'(goal_x_q) - 18'(rx_m);
		gdy_c   = 18'(goal_y_q) - 18'(ry_m);
	end

	logic signed [17:0] dvx_s1, dvy_s1, gdx_s1, gdy_s1;
	logic signed [16:0] th_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			dvx_s1 <= dvx_c;
			dvy_s1 <= dvy_c;
			gdx_s1 <= gdx_c;
			gdy_s1 <= gdy_c;
			th_s1  <= th_c;
		end
	end

	// stage 2: translation products, cordic pre-rotation
	logic signed [26:0] pvx_c, pvy_c;
	cor_word_t          x0_c, y0_c, z0_c;

	always_comb begin
		pvx_c = 27'($signed({1'b0, gain_xy_q})) * 27'(dvx_s1);
		pvy_c = 27'($signed({1'b0, gain_xy_q})) * 27'(dvy_s1);
		x0_c  = CW'(gdx_s1) <<< 8;
		y0_c  = CW'(gdy_s1) <<< 8;
		z0_c  = '0;
		// left half plane: turn by pi first
		if (x0_c < 0) begin
			z0_c = (y0_c >= 0) ? CW'(PI_Q24) : -CW'(PI_Q24);
			x0_c = -x0_c;
			y0_c = -y0_c;
		end
	end

	logic signed [26:0] pvx_s2, pvy_s2;
	cor_word_t          x_s2, y_s2, z_s2;
	logic               zero_s2;
	logic signed [16:0] th_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			pvx_s2  <= pvx_c;
			pvy_s2  <= pvy_c;
			x_s2    <= x0_c;
			y_s2    <= y0_c;
			z_s2    <= z0_c;
			zero_s2 <= (gdx_s1 == '0) && (gdy_s1 == '0);
			th_s2   <= th_s1;
		end
	end

	// velocity rounding and clamp, folded into the first cordic stage
	cor_t               cor_head;
	logic signed [27:0] rvx_c, rvy_c;
	logic signed [15:0] cvx_c, cvy_c;
	logic               away_s2;

	assign away_s2 = team_away_q;

	always_comb begin
		rvx_c         = (28'(pvx_s2) + 28'sd8) >>> 4;
		rvy_c         = (28'(pvy_s2) + 28'sd8) >>> 4;
		cvx_c         = clamp_sym(24'(rvx_c), max_speed_xy_q);
		cvy_c         = clamp_sym(24'(rvy_c), max_speed_xy_q);
		cor_head.x    = x_s2;
		cor_head.y    = y_s2;
		cor_head.z    = z_s2;
		cor_head.zero = zero_s2;
		cor_head.th   = th_s2;
		cor_head.vx   = away_s2 ? -cvx_c : cvx_c;
		cor_head.vy   = away_s2 ? -cvy_c : cvy_c;
	end

	// stage 3: vectoring cordic, one iteration per stage
	cor_t cor_s3 [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cor
		cor_t cur, nxt;
		logic vin;

		if (i == 0) begin : g_first
			assign cur = cor_head;
			assign vin = v_s2;
		end else begin : g_next
			assign cur = cor_s3[i-1];
			assign vin = cv_s3[i-1];
		end

		if (i == CORDIC_STEPS - 1) begin : g_last_rdy
			assign c_rdy[i] = !cv_s3[i] || rdy_s4;
		end else begin : g_mid_rdy
			assign c_rdy[i] = !cv_s3[i] || c_rdy[i+1];
		end

		always_comb begin
			nxt = cur;
			if (cur.y > 0) begin
				nxt.x = cur.x + (cur.y >>> i);
				nxt.y = cur.y - (cur.x >>> i);
				nxt.z = cur.z + ATAN_Q24[i];
			end else begin
				nxt.x = cur.x - (cur.y >>> i);
				nxt.y = cur.y + (cur.x >>> i);
				nxt.z = cur.z - ATAN_Q24[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s3[i] <= 1'b0;
			end else if (c_rdy[i]) begin
				cv_s3[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (c_rdy[i]) begin
				cor_s3[i] <= nxt;
			end
		end
	end

	// stage 4: goal angle to Q4.12, heading error
	cor_t               cor_tail;
	logic signed [27:0] zr_c;
	logic signed [15:0] td_c;
	logic signed [17:0] herr_c;

	assign cor_tail = cor_s3[CORDIC_STEPS-1];

	always_comb begin
		zr_c   = (cor_tail.z + 28'sd2048) >>> 12;
		td_c   = cor_tail.zero ? 16'sd0 : 16'(zr_c);
		herr_c = 18'(cor_tail.th) - 18'(td_c);
	end

	logic signed [17:0] herr_s4;
	logic signed [15:0] vx_s4, vy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= cv_s3[CORDIC_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			herr_s4 <= herr_c;
			vx_s4   <= cor_tail.vx;
			vy_s4   <= cor_tail.vy;
		end
	end

	// stage 5: heading product
	logic signed [26:0] pw_s5;
	logic signed [15:0] vx_s5, vy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			pw_s5 <= 27'($signed({1'b0, gain_turn_q})) * 27'(herr_s4);
			vx_s5 <= vx_s4;
			vy_s5 <= vy_s4;
		end
	end

	// stage 6: negate, round, clamp turn rate into the output register
	logic signed [27:0] rw_c;
	logic signed [15:0] w_c;
	logic [47:0]        out_s6;

	always_comb begin
		rw_c = (28'sd8 - 28'(pw_s5)) >>> 4;
		w_c  = clamp_sym(24'(rw_c), max_turn_rate_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (rdy_s6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			out_s6 <= {w_c, vy_s5, vx_s5};
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = out_s6;

endmodule

FILE: rtl/pvc_checker.sv
// pvc_checker: port-level assertions for the pose velocity controller, bound to the top level
module pvc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// a stalled result holds its beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// an empty output register means the pipe can take a beat
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	// a draining output frees the entry stage
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |-> s_tready)
		else $error("input blocked while output drains");

	// register writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind pose_velocity_controller_top pvc_checker u_pvc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
